>>> hw/rtl/rmrs_pkg.sv
// ----------------------------------------------------------------------------
// Range multiply / range sum tree package
// Shared widths, codes, the command record and modular helpers.
// ----------------------------------------------------------------------------
package rmrs_pkg;

  localparam int unsigned VAL_W      = 30;
  localparam int unsigned RS_W       = 10;
  localparam int unsigned RE_W       = 11;
  localparam int unsigned MUL_STEPS  = 30;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned DEF_LEAVES = 1024;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

  localparam logic CMD_SCALE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             query;
    logic             empty;
    logic [RE_W-1:0]  a;
    logic [RE_W-1:0]  b;
    logic [VAL_W-1:0] factor;
  } cmd_t;

  typedef struct packed {
    logic init_done;
  } eng_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_VISIT,
    S_LEAF_RD,
    S_LEAF_MS,
    S_LEAF_MF,
    S_RET,
    S_CMB_RD,
    S_CMB_RD2,
    S_CMB_WAIT,
    S_CMB_ADD,
    S_CMB_MUL,
    S_OUT
  } eng_state_e;

  // Both operands are below the modulus, so one subtraction suffices.
  function automatic logic [VAL_W-1:0] addmod(input logic [VAL_W-1:0] x,
                                              input logic [VAL_W-1:0] y);
    logic [VAL_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

>>> hw/rtl/rmrs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmrs_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rmrs_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Shift-and-add multiplication modulo the prime, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module rmrs_modmul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rmrs_pkg::VAL_W-1:0] a_i,
  input  logic [rmrs_pkg::VAL_W-1:0] b_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [rmrs_pkg::VAL_W-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(rmrs_pkg::MUL_STEPS);
  localparam logic [31:0] P1 = {2'b00, rmrs_pkg::PRIME};
  localparam logic [31:0] P2 = {1'b0, rmrs_pkg::PRIME, 1'b0};

  logic                       busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [rmrs_pkg::VAL_W-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [31:0]                t;

  always_comb begin
    t = {1'b0, acc_q, 1'b0} + (b_q[rmrs_pkg::VAL_W-1] ? {2'b00, a_q} : 32'd0);
    if (t >= P2) begin
      t = t - P2;
    end else if (t >= P1) begin
      t = t - P1;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = t[rmrs_pkg::VAL_W-1:0];
      b_d   = {b_q[rmrs_pkg::VAL_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(rmrs_pkg::MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign busy_o   = busy_q;
  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

>>> hw/rtl/rmrs_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts commands, clamps the range, reduces the factor, drops empty scales.
// ----------------------------------------------------------------------------
module rmrs_front #(
  parameter int unsigned LEAVES = rmrs_pkg::DEF_LEAVES
) (
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [55:0]                s_axis_tdata_i,
  input  logic                       s_axis_tuser_i,
  input  rmrs_pkg::eng_status_t      status_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output rmrs_pkg::cmd_t             q_data_o
);

  localparam int unsigned PW = $clog2(LEAVES) + 1;
  localparam int unsigned CW = (PW > rmrs_pkg::RE_W) ? PW : rmrs_pkg::RE_W;

  logic [CW-1:0]              start_x, end_x, lim;
  logic [CW-1:0]              a_c, b_c;
  logic [rmrs_pkg::VAL_W-1:0] f_raw;

  always_comb begin
    lim     = CW'(LEAVES);
    start_x = CW'(s_axis_tdata_i[rmrs_pkg::RS_W-1:0]);
    end_x   = CW'(s_axis_tdata_i[rmrs_pkg::RS_W+rmrs_pkg::RE_W-1:rmrs_pkg::RS_W]);
    f_raw   = s_axis_tdata_i[rmrs_pkg::RS_W+rmrs_pkg::RE_W+rmrs_pkg::VAL_W-1:
                             rmrs_pkg::RS_W+rmrs_pkg::RE_W];
    a_c     = (start_x > lim) ? lim : start_x;
    b_c     = (end_x > lim) ? lim : end_x;

    q_data_o.query  = (s_axis_tuser_i == rmrs_pkg::CMD_QUERY);
    q_data_o.empty  = (a_c >= b_c);
    q_data_o.a      = a_c[rmrs_pkg::RE_W-1:0];
    q_data_o.b      = b_c[rmrs_pkg::RE_W-1:0];
    // A raw factor is below twice the modulus.
    q_data_o.factor = (f_raw >= rmrs_pkg::PRIME) ? f_raw - rmrs_pkg::PRIME : f_raw;
  end

  assign s_axis_tready_o = status_i.init_done && !q_full_i;
  // A scale over an empty range has no effect and is not queued.
  assign q_push_o = s_axis_tvalid_i && s_axis_tready_o &&
                    (q_data_o.query || !q_data_o.empty);

endmodule

>>> hw/rtl/rmrs_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short register FIFO between the front end and the tree engine.
// ----------------------------------------------------------------------------
module rmrs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rmrs_pkg::cmd_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output rmrs_pkg::cmd_t data_o
);

  localparam int unsigned PTR_W = $clog2(rmrs_pkg::QDEPTH);

  rmrs_pkg::cmd_t     slot_q [rmrs_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [PTR_W:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == (PTR_W+1)'(rmrs_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

endmodule

>>> hw/rtl/rmrs_engine.sv
// ----------------------------------------------------------------------------
// Tree engine
// Walks the segment tree depth first with a level stack and applies commands.
// ----------------------------------------------------------------------------
module rmrs_engine #(
  parameter int unsigned LEAVES = rmrs_pkg::DEF_LEAVES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  rmrs_pkg::cmd_t        q_data_i,
  output logic                  q_pop_o,
  output rmrs_pkg::eng_status_t status_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [31:0]           m_axis_tdata_o
);

  localparam int unsigned VW    = rmrs_pkg::VAL_W;
  localparam int unsigned LVL_W = $clog2(LEAVES);
  localparam int unsigned SPAN  = 1 << LVL_W;
  localparam int unsigned NODES = 2 * SPAN;
  localparam int unsigned NAW   = LVL_W + 1;
  localparam int unsigned PW    = LVL_W + 1;
  localparam int unsigned LV_W  = $clog2(LVL_W + 1);
  localparam int unsigned STK_D = 1 << LV_W;
  localparam int unsigned CW    = (PW > rmrs_pkg::RE_W) ? PW : rmrs_pkg::RE_W;

  rmrs_pkg::eng_state_e state_q, state_d;
  rmrs_pkg::cmd_t       cmd_q;
  logic [LV_W-1:0]      lvl_q, p;
  logic [PW-1:0]        lo_q, w, hi;
  logic [VW-1:0]        ret_q, l_q, r_q, fx_q;
  logic [PW-1:0]        stk_lo_q  [STK_D];
  logic                 stk_ph_q  [STK_D];
  logic [VW-1:0]        stk_acc_q [STK_D];
  logic [NAW-1:0]       init_cnt_q;
  logic [LV_W-1:0]      init_lvl_q;
  logic                 out_valid_q;
  logic [VW-1:0]        out_data_q;

  logic [NAW-1:0]       node_x, child_l, child_r;
  logic [CW-1:0]        a_x, b_x, lo_x, hi_x;
  logic                 outside, covered, init_last, out_load;

  logic                 sum_we, fac_we, sum_re, fac_re;
  logic [NAW-1:0]       sum_wa, fac_wa, sum_ra, fac_ra;
  logic [VW-1:0]        sum_wd, fac_wd, sum_rd, fac_rd;
  logic                 mul_start, mul_busy, mul_done;
  logic [VW-1:0]        mul_a, mul_b, mul_res;

  always_comb begin
    w       = PW'(SPAN) >> lvl_q;
    hi      = lo_q + w;
    p       = lvl_q - LV_W'(1);
    node_x  = (NAW'(lo_q) >> (LV_W'(LVL_W) - lvl_q)) + (NAW'(1) << lvl_q) - NAW'(1);
    child_l = {node_x[NAW-2:0], 1'b1};
    child_r = NAW'({node_x[NAW-2:0], 1'b0}) + NAW'(2);
    a_x     = CW'(cmd_q.a);
    b_x     = CW'(cmd_q.b);
    lo_x    = CW'(lo_q);
    hi_x    = CW'(hi);
    outside = (hi_x <= a_x) || (b_x <= lo_x);
    covered = (a_x <= lo_x) && (hi_x <= b_x);
    init_last = (init_cnt_q == NAW'(NODES - 2));
    out_load  = !out_valid_q || m_axis_tready_i;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmrs_pkg::S_INIT:    if (init_last) state_d = rmrs_pkg::S_IDLE;
      rmrs_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (!q_data_i.empty) begin
            state_d = rmrs_pkg::S_VISIT;
          end else if (q_data_i.query) begin
            state_d = rmrs_pkg::S_OUT;
          end
        end
      end
      rmrs_pkg::S_VISIT: begin
        if (outside) begin
          state_d = rmrs_pkg::S_RET;
        end else if (covered) begin
          state_d = rmrs_pkg::S_LEAF_RD;
        end
      end
      rmrs_pkg::S_LEAF_RD:
        state_d = cmd_q.query ? rmrs_pkg::S_RET : rmrs_pkg::S_LEAF_MS;
      rmrs_pkg::S_LEAF_MS: if (mul_done) state_d = rmrs_pkg::S_LEAF_MF;
      rmrs_pkg::S_LEAF_MF: if (mul_done) state_d = rmrs_pkg::S_RET;
      rmrs_pkg::S_RET: begin
        if (lvl_q == '0) begin
          state_d = cmd_q.query ? rmrs_pkg::S_OUT : rmrs_pkg::S_IDLE;
        end else if (!stk_ph_q[p]) begin
          state_d = rmrs_pkg::S_VISIT;
        end else begin
          state_d = rmrs_pkg::S_CMB_RD;
        end
      end
      rmrs_pkg::S_CMB_RD:   state_d = rmrs_pkg::S_CMB_RD2;
      rmrs_pkg::S_CMB_RD2:  state_d = rmrs_pkg::S_CMB_WAIT;
      rmrs_pkg::S_CMB_WAIT: state_d = rmrs_pkg::S_CMB_ADD;
      rmrs_pkg::S_CMB_ADD:  state_d = rmrs_pkg::S_CMB_MUL;
      rmrs_pkg::S_CMB_MUL:  if (mul_done) state_d = rmrs_pkg::S_RET;
      rmrs_pkg::S_OUT:      if (out_load) state_d = rmrs_pkg::S_IDLE;
      default:              state_d = rmrs_pkg::S_INIT;
    endcase
  end

  // Memory and multiplier controls.
  always_comb begin
    sum_we    = 1'b0;
    fac_we    = 1'b0;
    sum_wa    = node_x;
    fac_wa    = node_x;
    sum_wd    = ret_q;
    fac_wd    = mul_res;
    sum_re    = 1'b0;
    fac_re    = 1'b0;
    sum_ra    = node_x;
    fac_ra    = node_x;
    mul_start = 1'b0;
    mul_a     = sum_rd;
    mul_b     = cmd_q.factor;
    q_pop_o   = 1'b0;
    unique case (state_q)
      rmrs_pkg::S_INIT: begin
        sum_we = 1'b1;
        fac_we = 1'b1;
        sum_wa = init_cnt_q;
        fac_wa = init_cnt_q;
        sum_wd = VW'(PW'(SPAN) >> init_lvl_q);
        fac_wd = VW'(1);
      end
      rmrs_pkg::S_IDLE:  q_pop_o = q_valid_i;
      rmrs_pkg::S_VISIT: begin
        sum_re = !outside && covered;
        fac_re = !outside && covered;
      end
      rmrs_pkg::S_LEAF_RD: mul_start = !cmd_q.query;
      rmrs_pkg::S_LEAF_MS: begin
        mul_start = mul_done;
        mul_a     = fx_q;
      end
      rmrs_pkg::S_LEAF_MF: begin
        sum_we = mul_done;
        fac_we = mul_done;
      end
      rmrs_pkg::S_CMB_RD: begin
        sum_re = 1'b1;
        fac_re = 1'b1;
        sum_ra = child_l;
      end
      rmrs_pkg::S_CMB_RD2: begin
        sum_re = 1'b1;
        sum_ra = child_r;
      end
      rmrs_pkg::S_CMB_ADD: begin
        mul_start = 1'b1;
        mul_a     = rmrs_pkg::addmod(l_q, r_q);
        mul_b     = fx_q;
      end
      rmrs_pkg::S_CMB_MUL: begin
        sum_we = mul_done && !cmd_q.query;
        sum_wd = mul_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmrs_pkg::S_INIT;
      lvl_q       <= '0;
      init_cnt_q  <= '0;
      init_lvl_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rmrs_pkg::S_INIT) begin
        init_cnt_q <= init_cnt_q + NAW'(1);
        if ((NAW+1)'(init_cnt_q) == ((NAW+1)'(2) << init_lvl_q) - (NAW+1)'(2)) begin
          init_lvl_q <= init_lvl_q + LV_W'(1);
        end
      end
      if (state_q == rmrs_pkg::S_IDLE) begin
        lvl_q <= '0;
      end else if (state_q == rmrs_pkg::S_VISIT && !outside && !covered) begin
        lvl_q <= lvl_q + LV_W'(1);
      end else if (state_q == rmrs_pkg::S_RET && lvl_q != '0 && stk_ph_q[p]) begin
        lvl_q <= p;
      end
      if (state_q == rmrs_pkg::S_OUT && out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rmrs_pkg::S_IDLE: begin
        cmd_q <= q_data_i;
        lo_q  <= '0;
        ret_q <= '0;
      end
      rmrs_pkg::S_VISIT: begin
        if (outside) begin
          ret_q <= '0;
        end else if (!covered) begin
          stk_lo_q[lvl_q] <= lo_q;
          stk_ph_q[lvl_q] <= 1'b0;
        end
      end
      rmrs_pkg::S_LEAF_RD: begin
        ret_q <= sum_rd;
        fx_q  <= fac_rd;
      end
      rmrs_pkg::S_LEAF_MS: if (mul_done) ret_q <= mul_res;
      rmrs_pkg::S_RET: begin
        if (lvl_q != '0) begin
          if (!stk_ph_q[p]) begin
            stk_acc_q[p] <= ret_q;
            stk_ph_q[p]  <= 1'b1;
            lo_q         <= stk_lo_q[p] + w;
          end else begin
            lo_q <= stk_lo_q[p];
            l_q  <= stk_acc_q[p];
            r_q  <= ret_q;
          end
        end
      end
      rmrs_pkg::S_CMB_RD2: begin
        fx_q <= fac_rd;
        if (!cmd_q.query) l_q <= sum_rd;
      end
      rmrs_pkg::S_CMB_WAIT: if (!cmd_q.query) r_q <= sum_rd;
      rmrs_pkg::S_CMB_MUL:  if (mul_done) ret_q <= mul_res;
      rmrs_pkg::S_OUT:      if (out_load) out_data_q <= ret_q;
      default: ;
    endcase
  end

  rmrs_ram #(.WIDTH(VW), .DEPTH(NODES)) u_sum_ram (
    .clk_i, .we_i(sum_we), .waddr_i(sum_wa), .wdata_i(sum_wd),
    .re_i(sum_re), .raddr_i(sum_ra), .rdata_o(sum_rd)
  );

  rmrs_ram #(.WIDTH(VW), .DEPTH(NODES)) u_fac_ram (
    .clk_i, .we_i(fac_we), .waddr_i(fac_wa), .wdata_i(fac_wd),
    .re_i(fac_re), .raddr_i(fac_ra), .rdata_o(fac_rd)
  );

  rmrs_modmul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .done_o(mul_done), .result_o(mul_res)
  );

  assign status_o.init_done = (state_q != rmrs_pkg::S_INIT);
  assign m_axis_tvalid_o    = out_valid_q;
  assign m_axis_tdata_o     = {{(32-VW){1'b0}}, out_data_q};

  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy) else $error("multiplier restarted while busy");

  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmrs_pkg::S_INIT) |-> !q_pop_o) else $error("command taken during clear");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LV_W'(LVL_W)) else $error("walk went below the leaf level");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(out_data_q))
    else $error("pending result overwritten");

endmodule

>>> hw/rtl/range_multiply_range_sum_tree.sv
// ----------------------------------------------------------------------------
// Range multiply / range sum segment tree
// Top level: front end, command queue and tree engine.
// ----------------------------------------------------------------------------
// The slave stream carries commands: tuser is the command (0 scales the range
// [range_start, range_end) by factor, 1 asks for the range sum), tdata holds
// the range and the factor. The master stream returns one 30-bit sum per
// query; scales return nothing. All arithmetic is modulo 1000000007.
// After reset the engine writes the initial tree into the node memories, one
// node a cycle, 2*SPAN-1 nodes in all (SPAN is LEAVES rounded up to a power
// of two); tready stays low meanwhile. Commands then pass through a two-entry
// queue, so the front accepts while the engine walks, until the queue is full.
// The engine handles one command at a time. Each modular multiply runs in the
// shared bit-serial multiplier: a fully covered node costs two multiplies on
// a scale, and every partly covered node one more on the way back up. A
// command thus takes up to about 4*log2(SPAN) visits; a scale needs up to
// about 6*log2(SPAN) multiplies and a query up to about 2*log2(SPAN).
// A result waits in the output register while the receiver stalls; the
// engine blocks only when a second result is ready.
// ----------------------------------------------------------------------------
module range_multiply_range_sum_tree #(
  parameter int unsigned LEAVES = rmrs_pkg::DEF_LEAVES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // range_start, range_end, factor, zero pad
  input  logic        s_axis_tuser_i,  // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // range_sum, zero pad
);

  rmrs_pkg::eng_status_t status;
  rmrs_pkg::cmd_t        push_data, pop_data;
  logic                  q_push, q_pop, q_full, q_valid;

  rmrs_front #(.LEAVES(LEAVES)) u_front (
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .status_i(status), .q_full_i(q_full), .q_push_o(q_push), .q_data_o(push_data)
  );

  rmrs_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(push_data), .pop_i(q_pop),
    .full_o(q_full), .valid_o(q_valid), .data_o(pop_data)
  );

  rmrs_engine #(.LEAVES(LEAVES)) u_engine (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(pop_data), .q_pop_o(q_pop),
    .status_o(status), .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

endmodule
